FILE: rtl/racp_pkg.sv
// Package with shared constants and types for the running autocorrelation pitch block.
package racp_pkg;
	localparam int HistDepth  = 2048;
	localparam int LagSlots   = 1024;
	localparam int SampleBits = 16;
	localparam int HistAw     = $clog2(HistDepth);
	localparam int LagAw      = $clog2(LagSlots);
	localparam int AccBits    = 48;
	localparam int ProdBits   = 2 * SampleBits;

	localparam logic [1:0] RegWindow    = 2'd0;
	localparam logic [1:0] RegThreshold = 2'd1;
	localparam logic [1:0] RegMinLag    = 2'd2;
	localparam logic [1:0] RegMaxLag    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_OLD,
		ST_LAG,
		ST_DRAIN,
		ST_OUT
	} state_t;
endpackage

FILE: rtl/racp_ram.sv
// Generic single-port-write, registered-read RAM.
module racp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/running_autocorrelation_pitch_top.sv
// Throughput: one sample per result; the lag walk reads two history words per lag
// through the single history read port.
// Reset: arst_n clears control state, then a clearing pass over all 2048 history
// addresses zeroes the history and correlation memories before the first sample is taken.
// The result register holds a finished transaction while the output is stalled; the next
// sample is taken meanwhile and its result waits in the last state until the register frees.
module running_autocorrelation_pitch_top import racp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_in,
	output logic                    stall_in,
	input  logic signed [SampleBits-1:0] sample,
	output logic                    valid_out,
	input  logic                    stall_out,
	output logic [9:0]              best_lag,
	output logic                    silent,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [AccBits-1:0]      cfg_data
);
	state_t state_q, state_d;

	logic [10:0]        window_q;
	logic [AccBits-1:0] thresh_q;
	logic [9:0]         min_lag_q, max_lag_q;

	logic [HistAw:0]    clr_q;
	logic [HistAw-1:0]  ptr_q;
	logic signed [SampleBits-1:0] x_q, old_q, hb_q;
	logic [AccBits-1:0] energy_q;
	logic [LagAw:0]     lag_q;
	logic               phase_q;
	logic [LagAw:0]     hi;

	// Pipeline for the correlation update: stage 1 has both products.
	logic               v_s1;
	logic [LagAw-1:0]   lag_s1;
	logic signed [ProdBits-1:0] add_s1, sub_s1;
	logic               v_s2;
	logic [LagAw-1:0]   lag_s2;
	logic [AccBits-1:0] corr_s2;

	logic signed [AccBits-1:0] best_q;
	logic [9:0]         best_lag_q;
	logic               res_valid_q, res_silent_q;
	logic [9:0]         res_lag_q;
	logic               out_free;

	// History RAM ports.
	logic               h_we;
	logic [HistAw-1:0]  h_waddr, h_raddr;
	logic [SampleBits-1:0] h_wdata, h_rdata;
	// Correlation RAM ports.
	logic               c_we;
	logic [LagAw-1:0]   c_waddr, c_raddr;
	logic [AccBits-1:0] c_wdata, c_rdata;

	// Phase tracking: read issued in phase p returns in the following cycle.
	logic p0_ret_q, p1_ret_q;
	logic [LagAw-1:0] lag_ret_q;

	racp_ram #(.Width(SampleBits), .Depth(HistDepth)) u_hist (
		.clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
	);
	racp_ram #(.Width(AccBits), .Depth(LagSlots)) u_corr (
		.clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
	);

	assign hi = (max_lag_q > 10'(LagSlots - 1)) ? (LagAw+1)'(LagSlots)
		: (LagAw+1)'(max_lag_q);

	logic lag_done;
	assign lag_done = (lag_q >= hi);

	// The result register can take a new result when it is empty or being read out.
	assign out_free = !res_valid_q || !stall_out;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (HistAw+1)'(HistDepth - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (valid_in) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OLD;
			ST_OLD:   state_d = ST_LAG;
			ST_LAG:   if (lag_done && phase_q == 1'b0) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		stall_in = !(state_q == ST_IDLE);
		h_we     = 1'b0;
		h_waddr  = ptr_q;
		h_wdata  = sample;
		h_raddr  = ptr_q;
		c_we     = 1'b0;
		c_waddr  = lag_s2;
		c_wdata  = corr_s2;
		c_raddr  = lag_ret_q;
		case (state_q)
			ST_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q[HistAw-1:0];
				h_wdata = '0;
				c_we    = 1'b1;
				c_waddr = clr_q[LagAw-1:0];
				c_wdata = '0;
			end
			ST_IDLE: begin
				h_we = valid_in;
			end
			ST_WRITE: begin
				h_raddr = ptr_q - HistAw'(window_q);
			end
			ST_LAG: begin
				// Phase 0 reads x[n-lag], phase 1 reads x[n-W-lag].
				if (phase_q == 1'b0) h_raddr = ptr_q - HistAw'(lag_q);
				else h_raddr = ptr_q - HistAw'(window_q) - HistAw'(lag_q);
				c_we = v_s2;
			end
			ST_DRAIN: c_we = v_s2;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			window_q    <= 11'd1024;
			thresh_q    <= 48'd27487790;
			min_lag_q   <= 10'd54;
			max_lag_q   <= 10'd512;
			ptr_q       <= '0;
			energy_q    <= '0;
			lag_q       <= '0;
			phase_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			p0_ret_q    <= 1'b0;
			p1_ret_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					RegWindow:    window_q  <= cfg_data[10:0];
					RegThreshold: thresh_q  <= cfg_data;
					RegMinLag:    min_lag_q <= cfg_data[9:0];
					RegMaxLag:    max_lag_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			p0_ret_q <= (state_q == ST_LAG) && !lag_done && !phase_q;
			p1_ret_q <= (state_q == ST_LAG) && phase_q;
			v_s1     <= p1_ret_q;
			v_s2     <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (valid_in) x_q <= sample;
					lag_q   <= (LagAw+1)'(min_lag_q);
					phase_q <= 1'b0;
					best_q  <= '0;
					best_lag_q <= min_lag_q;
				end
				ST_OLD: begin
					old_q    <= $signed(h_rdata);
					energy_q <= energy_q + AccBits'(ProdBits'(x_q) * ProdBits'(x_q))
						- AccBits'(ProdBits'($signed(h_rdata)) * ProdBits'($signed(h_rdata)));
				end
				ST_LAG: begin
					if (phase_q) begin
						phase_q <= 1'b0;
						lag_q   <= lag_q + 1'b1;
					end else if (!lag_done) begin
						phase_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						res_silent_q <= energy_q < thresh_q;
						res_lag_q    <= (energy_q < thresh_q) ? 10'd0 : best_lag_q;
						ptr_q        <= ptr_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == ST_OUT && out_free) res_valid_q <= 1'b1;
			else if (res_valid_q && !stall_out) res_valid_q <= 1'b0;
			// The correlation read for lag_ret_q goes out with the phase 1 data and
			// lands together with the products.
			if (p0_ret_q) hb_q <= $signed(h_rdata);
			if (p1_ret_q) begin
				add_s1 <= x_q * hb_q;
				sub_s1 <= old_q * $signed(h_rdata);
				lag_s1 <= lag_ret_q;
			end
			if (v_s1) begin
				corr_s2 <= c_rdata + AccBits'(add_s1) - AccBits'(sub_s1);
				lag_s2  <= lag_s1;
			end
			if (v_s2 && $signed(corr_s2) > best_q) begin
				best_q     <= $signed(corr_s2);
				best_lag_q <= 10'(lag_s2);
			end
		end
	end

	// The lag of a returned phase 0 read also addresses the correlation read.
	always_ff @(posedge clk) begin
		if (p0_ret_q) lag_ret_q <= lag_q[LagAw-1:0];
	end

	assign valid_out = res_valid_q;
	assign best_lag  = res_lag_q;
	assign silent    = res_silent_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> stall_in) else $error("input taken while busy");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && stall_out) |=> (valid_out && $stable(best_lag))) else
		$error("result dropped under stall");
	a_pipe_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (!v_s1 && !v_s2)) else $error("update in flight at result");
`endif
endmodule
